>>> src/psd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the port scan detector.
// ----------------------------------------------------------------------------
package psd_pkg;

	// Table geometry. BUCKETS and PORTS_PER_SOURCE are powers of two so that
	// the bucket and the port slot come straight from address bits.
	localparam int BUCKETS          = 64;
	localparam int WAYS             = 4;
	localparam int PORTS_PER_SOURCE = 64;

	localparam int unsigned US_PER_SECOND = 1000000;

	typedef enum logic [1:0] {
		KIND_SYN  = 2'd0,
		KIND_FIN  = 2'd1,
		KIND_NULL = 2'd2,
		KIND_XMAS = 2'd3
	} kind_t;

	typedef enum logic {
		OP_CHECK = 1'b0,
		OP_SWEEP = 1'b1
	} op_t;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_WINDOW    = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_WAYRD,
		ST_WAYCMP,
		ST_EXPIRE,
		ST_PORTRD,
		ST_PORTCMP,
		ST_FINISH,
		ST_SWRD,
		ST_SWCMP,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;      // capture input item
		logic calc_lim;  // compute window and sweep limits
		logic way_rd;    // read entry at current way
		logic way_cmp;   // evaluate read entry, step way
		logic expire;    // allocate / apply window expiry
		logic port_rd;   // read port slot
		logic port_cmp;  // compare port slot, step slot
		logic finish;    // append port, write entry, form result
		logic sw_rd;     // read entry at sweep index
		logic sw_cmp;    // evaluate sweep entry, step index
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic is_sweep;
		logic classified;
		logic way_last;
		logic no_room;
		logic port_done;
		logic port_hit;
		logic sw_last;
	} status_t;

	function automatic logic [2:0] classify(input logic [7:0] f);
		logic [2:0] r;
		r = 3'b000;
		if (f == 8'h02) r = {1'b1, KIND_SYN};
		else if (f == 8'h01) r = {1'b1, KIND_FIN};
		else if (f == 8'h00) r = {1'b1, KIND_NULL};
		else if ((f & 8'h29) == 8'h29) r = {1'b1, KIND_XMAS};
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/psd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer for one item at a time: check or sweep.
// ----------------------------------------------------------------------------
module psd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire logic             out_fire,
	input  wire psd_pkg::status_t sts,
	output logic                  busy,
	output logic                  res_valid,
	output psd_pkg::cmd_t         cmd
);
	psd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= psd_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psd_pkg::ST_IDLE:    if (in_fire) state_d = psd_pkg::ST_LIMIT;
			psd_pkg::ST_LIMIT: begin
				if (sts.is_sweep) state_d = psd_pkg::ST_SWRD;
				else if (sts.classified) state_d = psd_pkg::ST_WAYRD;
				else state_d = psd_pkg::ST_OUT;
			end
			psd_pkg::ST_WAYRD:   state_d = psd_pkg::ST_WAYCMP;
			psd_pkg::ST_WAYCMP:  state_d = sts.way_last ? psd_pkg::ST_EXPIRE
				: psd_pkg::ST_WAYRD;
			psd_pkg::ST_EXPIRE:  state_d = sts.no_room ? psd_pkg::ST_OUT
				: psd_pkg::ST_PORTRD;
			psd_pkg::ST_PORTRD:  state_d = sts.port_done ? psd_pkg::ST_FINISH
				: psd_pkg::ST_PORTCMP;
			psd_pkg::ST_PORTCMP: state_d = sts.port_hit ? psd_pkg::ST_FINISH
				: psd_pkg::ST_PORTRD;
			psd_pkg::ST_FINISH:  state_d = psd_pkg::ST_OUT;
			psd_pkg::ST_SWRD:    state_d = psd_pkg::ST_SWCMP;
			psd_pkg::ST_SWCMP:   state_d = sts.sw_last ? psd_pkg::ST_OUT
				: psd_pkg::ST_SWRD;
			psd_pkg::ST_OUT:     if (out_fire) state_d = psd_pkg::ST_IDLE;
			default:             state_d = psd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			psd_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
			end
			psd_pkg::ST_LIMIT:   cmd.calc_lim = 1'b1;
			psd_pkg::ST_WAYRD:   cmd.way_rd = 1'b1;
			psd_pkg::ST_WAYCMP:  cmd.way_cmp = 1'b1;
			psd_pkg::ST_EXPIRE:  cmd.expire = 1'b1;
			psd_pkg::ST_PORTRD:  cmd.port_rd = 1'b1;
			psd_pkg::ST_PORTCMP: cmd.port_cmp = 1'b1;
			psd_pkg::ST_FINISH:  cmd.finish = 1'b1;
			psd_pkg::ST_SWRD:    cmd.sw_rd = 1'b1;
			psd_pkg::ST_SWCMP:   cmd.sw_cmp = 1'b1;
			psd_pkg::ST_OUT:     res_valid = 1'b1;
			default:             busy = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

>>> src/psd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_datapath
// Entry table, port store, limits and result registers.
// ----------------------------------------------------------------------------
module psd_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire psd_pkg::cmd_t    cmd,
	input  wire logic             in_operation,
	input  wire logic [31:0]      in_source,
	input  wire logic [15:0]      in_port,
	input  wire logic [7:0]       in_flags,
	input  wire logic [63:0]      in_now,
	input  wire logic [6:0]       port_threshold,
	input  wire logic [11:0]      window_len,
	output psd_pkg::status_t      sts,
	output logic                  scan_detected,
	output logic [1:0]            scan_kind,
	output logic                  no_room,
	output logic                  ports_full,
	output logic [8:0]            removed_count
);
	localparam int PPS     = psd_pkg::PORTS_PER_SOURCE;
	localparam int ENTRIES = psd_pkg::BUCKETS * psd_pkg::WAYS;
	localparam int BW      = (psd_pkg::BUCKETS > 1) ? $clog2(psd_pkg::BUCKETS) : 1;
	localparam int WW      = (psd_pkg::WAYS > 1) ? $clog2(psd_pkg::WAYS) : 1;
	localparam int EW      = BW + WW;
	localparam int PW      = $clog2(PPS);
	localparam int CW      = $clog2(PPS + 1);
	localparam int SW      = EW + PW;
	localparam int RECW    = 32 + 64 + 64 + 2 + CW;

	// Entry memory: source, window start, last seen, kind, count.
	logic [RECW-1:0] ent_mem [ENTRIES];
	logic [15:0]     port_mem [PPS * ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [RECW-1:0] rd_q;
	logic [15:0]     prd_q;
	logic            rdv_q;

	logic        op_q;
	logic [31:0] src_q;
	logic [15:0] port_q;
	logic [63:0] now_q;
	logic [1:0]  kind_q;
	logic        cls_q;
	logic [63:0] win_q, lim_q;

	logic [WW-1:0] way_q;
	logic          hit_q, free_q;
	logic [WW-1:0] hitw_q, freew_q;
	logic [RECW-1:0] hitrec_q;
	logic [EW-1:0] sel_q;
	logic [63:0]   ws_q;
	logic [1:0]    ek_q;
	logic [CW-1:0] cnt_q, pi_q;
	logic          phit_q;
	logic [EW-1:0] swi_q;
	logic [8:0]    rem_q;

	logic [BW-1:0] bucket;
	logic [EW-1:0] rd_addr;
	logic [2:0]    cls;
	logic [31:0]   r_src;
	logic [63:0]   r_ls;
	logic [EW-1:0] way_ent, new_ent;
	logic [CW-1:0] fin_cnt;
	logic [31:0]   win_prod;

	assign cls = psd_pkg::classify(in_flags);
	assign bucket = src_q[BW-1:0];
	assign way_ent = {bucket, way_q};
	assign r_src = rd_q[RECW-1 -: 32];
	assign r_ls = rd_q[RECW-97 -: 64];
	assign rd_addr = cmd.sw_rd ? swi_q : way_ent;
	// Window in microseconds fits 32 bits for a 12-bit window in seconds.
	assign win_prod = 32'(window_len) * psd_pkg::US_PER_SECOND;

	always_ff @(posedge clk) begin
		if (cmd.way_rd || cmd.sw_rd) rd_q <= ent_mem[rd_addr];
		if (cmd.port_rd) prd_q <= port_mem[SW'({sel_q, PW'(pi_q)})];
		if (cmd.finish) begin
			ent_mem[sel_q] <= {src_q, ws_q, now_q, ek_q, fin_cnt};
			if (!phit_q && cnt_q < CW'(PPS))
				port_mem[SW'({sel_q, PW'(cnt_q)})] <= port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (cmd.way_rd) rdv_q <= valid_q[way_ent];
			if (cmd.sw_rd) rdv_q <= valid_q[swi_q];
			if (cmd.expire && !(!hit_q && !free_q)) valid_q[new_ent] <= 1'b1;
			if (cmd.sw_cmp && rdv_q && (now_q - r_ls > lim_q))
				valid_q[swi_q] <= 1'b0;
		end
	end

	assign new_ent = {bucket, (hit_q ? hitw_q : freew_q)};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_operation;
			src_q <= in_source;
			port_q <= in_port;
			now_q <= in_now;
			kind_q <= cls[1:0];
			cls_q <= cls[2];
		end
		if (cmd.calc_lim) begin
			win_q <= 64'(win_prod);
			lim_q <= {31'd0, win_prod, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q <= '0; hit_q <= 1'b0; free_q <= 1'b0; swi_q <= '0; rem_q <= '0;
			pi_q <= '0; phit_q <= 1'b0;
			hitw_q <= '0; freew_q <= '0; hitrec_q <= '0; sel_q <= '0;
			ws_q <= '0; ek_q <= '0; cnt_q <= '0;
			scan_detected <= 1'b0; scan_kind <= '0; no_room <= 1'b0;
			ports_full <= 1'b0; removed_count <= '0;
		end else begin
			if (cmd.load) begin
				way_q <= '0; hit_q <= 1'b0; free_q <= 1'b0; swi_q <= '0;
				rem_q <= '0; pi_q <= '0; phit_q <= 1'b0;
				scan_detected <= 1'b0; scan_kind <= '0; no_room <= 1'b0;
				ports_full <= 1'b0; removed_count <= '0;
			end
			if (cmd.way_cmp) begin
				way_q <= way_q + 1'b1;
				if (rdv_q) begin
					if (!hit_q && r_src == src_q) begin
						hit_q <= 1'b1; hitw_q <= way_q; hitrec_q <= rd_q;
					end
				end else if (!free_q) begin
					free_q <= 1'b1; freew_q <= way_q;
				end
			end
			if (cmd.expire) begin
				sel_q <= new_ent;
				if (!hit_q && !free_q) no_room <= 1'b1;
				if (!hit_q || (now_q - hitrec_q[RECW-33 -: 64] > win_q)) begin
					ws_q <= now_q; ek_q <= kind_q; cnt_q <= '0;
				end else begin
					ws_q <= hitrec_q[RECW-33 -: 64];
					ek_q <= hitrec_q[CW +: 2];
					cnt_q <= (hitrec_q[CW-1:0] > CW'(PPS)) ?
						CW'(PPS) : hitrec_q[CW-1:0];
				end
			end
			if (cmd.port_cmp) begin
				pi_q <= pi_q + 1'b1;
				if (prd_q == port_q) phit_q <= 1'b1;
			end
			if (cmd.finish) begin
				if (!phit_q && cnt_q >= CW'(PPS)) ports_full <= 1'b1;
				if (8'(fin_cnt) >= 8'(port_threshold)) begin
					scan_detected <= 1'b1; scan_kind <= ek_q;
				end
			end
			if (cmd.sw_cmp) begin
				swi_q <= swi_q + 1'b1;
				if (rdv_q && (now_q - r_ls > lim_q) && rem_q != 9'd511)
					rem_q <= rem_q + 1'b1;
			end
			if (cmd.sw_cmp && sts.sw_last)
				removed_count <= (rdv_q && (now_q - r_ls > lim_q) && rem_q != 9'd511)
					? rem_q + 1'b1 : rem_q;
		end
	end

	assign fin_cnt = (!phit_q && cnt_q < CW'(PPS)) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		sts.is_sweep   = op_q;
		sts.classified = cls_q;
		sts.way_last   = (32'(way_q) == psd_pkg::WAYS - 1);
		sts.no_room    = !hit_q && !free_q;
		sts.port_done  = (pi_q >= cnt_q);
		sts.port_hit   = (prd_q == port_q);
		sts.sw_last    = (32'(swi_q) == ENTRIES - 1);
	end
endmodule
`default_nettype wire

>>> src/port_scan_detector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// port_scan_detector_top
// Port scan detector with a set-associative source table.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A check walks the ways of the source's
// bucket and then the ports already stored for the source (the port store
// is a single-port memory read one slot at a time); a sweep walks the entry
// table one entry at a time.
// The table geometry (BUCKETS, WAYS, PORTS_PER_SOURCE) is fixed in the package.
// Configuration writes are taken while the block is idle.
module port_scan_detector_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: source_address[31:0], dest_port[47:32], flag_bits[55:48], now_us[119:56]
	input  wire logic [119:0] s_tdata,
	// tuser: operation
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata: scan_detected[0], scan_kind[2:1], no_room[3], ports_full[4],
	// removed_count[13:5]
	output logic [15:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [11:0]  cfg_data
);
	psd_pkg::cmd_t    cmd;
	psd_pkg::status_t sts;
	logic busy, res_valid;
	logic [6:0]  thr_q;
	logic [11:0] win_q;
	logic sd, nr, pf;
	logic [1:0] sk;
	logic [8:0] rc;

	assign s_tready  = !busy;
	assign cfg_ready = !busy;
	assign m_tvalid  = res_valid;
	assign m_tdata   = {2'b00, rc, pf, nr, sk, sd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 7'd20;
			win_q <= 12'd60;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				psd_pkg::REG_THRESHOLD: thr_q <= cfg_data[6:0];
				psd_pkg::REG_WINDOW:    win_q <= cfg_data;
				default:                thr_q <= thr_q;
			endcase
		end
	end

	psd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready),
		.sts, .busy, .res_valid, .cmd
	);

	psd_datapath u_dp (
		.clk, .arst_n, .cmd,
		.in_operation(s_tuser),
		.in_source(s_tdata[31:0]),
		.in_port(s_tdata[47:32]),
		.in_flags(s_tdata[55:48]),
		.in_now(s_tdata[119:56]),
		.port_threshold(thr_q),
		.window_len(win_q),
		.sts,
		.scan_detected(sd), .scan_kind(sk), .no_room(nr),
		.ports_full(pf), .removed_count(rc)
	);
endmodule
`default_nettype wire

>>> src/psd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the detector.
// ----------------------------------------------------------------------------
module psd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [15:0]  m_tdata
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed");
	a_kind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'b00)
		else $error("kind without detection");
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[0] && !m_tdata[4])
		else $error("no_room with other flags");
endmodule

bind port_scan_detector_top psd_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
